// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file ltfc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is low.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ltfc_pkg.sv =====
package ltfc_pkg;

  // Sample width and derived arithmetic widths
  localparam int ADC_BITS    = 12;
  localparam int DIVISOR     = 429;
  localparam int PROD_BITS   = ADC_BITS + 4;             // raw * 16
  localparam int Q_BITS      = PROD_BITS - 8;            // quotient, divisor > 256
  localparam int DEG_BITS    = ((Q_BITS > 7) ? Q_BITS : 7) + 1;
  localparam int FAN_BITS    = DEG_BITS + 4;

  // Reciprocal for the divide by 429, exact for all products below 2**PROD_BITS
  localparam int RECIP_SHIFT = PROD_BITS + 9;
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int RECIP_BITS  = RECIP_SHIFT - 8;
  localparam int MUL_BITS    = ADC_BITS + RECIP_BITS;

  // Stream widths
  localparam int IN_W        = ((3 * ADC_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 58;
  localparam int OUT_W       = ((OUT_BITS + 7) / 8) * 8;

  // Temperature and fan constants
  localparam logic signed [DEG_BITS-1:0] DEG_OFFSET = DEG_BITS'(94);
  localparam logic signed [DEG_BITS-1:0] HOT_DEG    = DEG_BITS'(80);
  localparam logic signed [FAN_BITS-1:0] FAN_OFFSET = FAN_BITS'(305);
  localparam logic signed [FAN_BITS-1:0] FAN_STEP   = FAN_BITS'(3);
  localparam logic signed [FAN_BITS-1:0] FAN_MAX    = FAN_BITS'(255);

  // LED level constants
  localparam logic [7:0] THROTTLE  = 8'd25;
  localparam logic [7:0] RED_CAP   = 8'd238;
  localparam logic [7:0] WHITE_CAP = 8'd242;
  localparam logic [7:0] BLUE_CAP  = 8'd242;
  localparam logic [7:0] FULL      = 8'd255;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RED   = 2'd0,
    CFG_WHITE = 2'd1,
    CFG_BLUE  = 2'd2
  } cfg_idx_t;

  // Result of one LED channel update
  typedef struct packed {
    logic       fault;
    logic [7:0] level;
  } led_res_t;

endpackage

// ===== hdl/ltfc_deg.sv =====
module ltfc_deg (
  input  logic [ltfc_pkg::ADC_BITS-1:0]        raw,
  output logic signed [ltfc_pkg::DEG_BITS-1:0] deg
);

  logic [ltfc_pkg::MUL_BITS-1:0] prod;
  logic [ltfc_pkg::Q_BITS-1:0]   quot;

  // (raw*16)/429 as a reciprocal multiply; the *16 folds into the shift
  assign prod = ltfc_pkg::MUL_BITS'(raw) *
                ltfc_pkg::MUL_BITS'(ltfc_pkg::RECIP);
  assign quot = prod[ltfc_pkg::MUL_BITS-1 -: ltfc_pkg::Q_BITS];

  assign deg = ltfc_pkg::DEG_OFFSET - signed'(ltfc_pkg::DEG_BITS'(quot));

endmodule

// ===== hdl/ltfc_led.sv =====
module ltfc_led (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 update,
  input  logic signed [ltfc_pkg::DEG_BITS-1:0] deg,
  input  logic [7:0]                           target,
  input  logic [7:0]                           cap,
  output ltfc_pkg::led_res_t                   res
);

  logic [7:0] level;
  logic [7:0] lvl_raw;
  logic       hot;

  assign hot = deg > ltfc_pkg::HOT_DEG;

  // Throttle while hot, fault if there is no room to throttle
  always_comb begin
    res.fault = 1'b0;
    lvl_raw   = target;
    if (hot) begin
      if (level < ltfc_pkg::THROTTLE) begin
        res.fault = 1'b1;
        lvl_raw   = level;
      end else begin
        lvl_raw = level - ltfc_pkg::THROTTLE;
      end
    end
    res.level = (lvl_raw > cap) ? cap : lvl_raw;
  end

  // Channel level state
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 8'd0;
    end else if (update) begin
      level <= res.level;
    end
  end

endmodule

// ===== hdl/led_thermal_fan_controller.sv =====
// LED thermal fan controller.
// Input stream s_*: one beat per control tick carrying the three raw sensor
// samples. Output stream m_*: one beat per tick with the fault flag, driver
// enable, the three LED PWM compares, the fan PWM compare and the three
// converted temperatures.
// Config port: cfg_wr_en with cfg_index 0/1/2 writes the red/white/blue
// target level; other indexes are ignored. Write only while idle.
// Path: an accepted beat waits in the input register and moves on to the
// output register and m_* once that is free. Throughput: one tick per cycle
// while m_tready is high; fan and LED levels update in the cycle that moves
// a tick to the output register, via one reciprocal multiplier per sensor.
// Stall: while m_tready is low the result holds and one more tick may wait
// in the input register; s_tready drops only when both are full.
// Reset: levels go to 0, LED compares to 255, fan compare to 0, the driver
// is enabled and both registers are emptied.
module led_thermal_fan_controller (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // s_tdata: red_raw, white_raw, blue_raw, zero fill
  input  logic [ltfc_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // m_tdata: over_temp_fault, driver_enable, red_compare, white_compare,
  //   blue_compare, fan_compare, red_degrees, white_degrees, blue_degrees
  output logic [ltfc_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_wr_en,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data
);

  localparam int AB = ltfc_pkg::ADC_BITS;
  localparam int DB = ltfc_pkg::DEG_BITS;
  localparam int FB = ltfc_pkg::FAN_BITS;

  logic [7:0] red_target, white_target, blue_target;

  logic          in_valid;
  logic [AB-1:0] red_raw, white_raw, blue_raw;
  logic          adv;

  logic signed [DB-1:0] red_deg, white_deg, blue_deg, max_deg;
  logic signed [FB-1:0] want, fan_cur, diff, fan_step;
  logic [7:0]           fan_level, fan_level_next;

  ltfc_pkg::led_res_t red_res, white_res, blue_res;
  logic               fault;

  logic       fault_q, driver_on;
  logic [7:0] red_cmp_hold, white_cmp_hold, blue_cmp_hold, fan_cmp_hold;
  logic [7:0] red_deg_q, white_deg_q, blue_deg_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_target   <= 8'd0;
      white_target <= 8'd0;
      blue_target  <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ltfc_pkg::CFG_RED:   red_target   <= cfg_data;
        ltfc_pkg::CFG_WHITE: white_target <= cfg_data;
        ltfc_pkg::CFG_BLUE:  blue_target  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the tick moves forward when the output register is free
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      red_raw   <= s_tdata[AB-1:0];
      white_raw <= s_tdata[2*AB-1:AB];
      blue_raw  <= s_tdata[3*AB-1:2*AB];
    end
  end

  // Temperature conversion
  ltfc_deg u_deg_red   (.raw(red_raw),   .deg(red_deg));
  ltfc_deg u_deg_white (.raw(white_raw), .deg(white_deg));
  ltfc_deg u_deg_blue  (.raw(blue_raw),  .deg(blue_deg));

  // Hottest sensor
  always_comb begin
    max_deg = red_deg;
    if (white_deg > max_deg) max_deg = white_deg;
    if (blue_deg > max_deg)  max_deg = blue_deg;
  end

  // Fan: slew toward max*8-305 by at most 3, then clamp to 0..255
  assign want    = (FB'(max_deg) <<< 3) - ltfc_pkg::FAN_OFFSET;
  assign fan_cur = signed'(FB'(fan_level));
  assign diff    = want - fan_cur;

  always_comb begin
    if (diff > ltfc_pkg::FAN_STEP) begin
      fan_step = fan_cur + ltfc_pkg::FAN_STEP;
    end else if (diff < -ltfc_pkg::FAN_STEP) begin
      fan_step = fan_cur - ltfc_pkg::FAN_STEP;
    end else begin
      fan_step = want;
    end
    if (fan_step < 0) begin
      fan_level_next = 8'd0;
    end else if (fan_step > ltfc_pkg::FAN_MAX) begin
      fan_level_next = 8'hFF;
    end else begin
      fan_level_next = fan_step[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fan_level <= 8'd0;
    end else if (adv) begin
      fan_level <= fan_level_next;
    end
  end

  // LED channels
  ltfc_led u_led_red (
    .clk(clk), .rst(rst), .update(adv), .deg(red_deg),
    .target(red_target), .cap(ltfc_pkg::RED_CAP), .res(red_res)
  );
  ltfc_led u_led_white (
    .clk(clk), .rst(rst), .update(adv), .deg(white_deg),
    .target(white_target), .cap(ltfc_pkg::WHITE_CAP), .res(white_res)
  );
  ltfc_led u_led_blue (
    .clk(clk), .rst(rst), .update(adv), .deg(blue_deg),
    .target(blue_target), .cap(ltfc_pkg::BLUE_CAP), .res(blue_res)
  );

  assign fault = red_res.fault | white_res.fault | blue_res.fault;

  // Output register and compare holds
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid       <= 1'b0;
      fault_q        <= 1'b0;
      driver_on      <= 1'b1;
      red_cmp_hold   <= ltfc_pkg::FULL;
      white_cmp_hold <= ltfc_pkg::FULL;
      blue_cmp_hold  <= ltfc_pkg::FULL;
      fan_cmp_hold   <= 8'd0;
    end else if (adv) begin
      m_tvalid  <= 1'b1;
      fault_q   <= fault;
      driver_on <= !fault;
      if (fault) begin
        fan_cmp_hold <= ltfc_pkg::FULL;
      end else begin
        red_cmp_hold   <= ltfc_pkg::FULL - red_res.level;
        white_cmp_hold <= ltfc_pkg::FULL - white_res.level;
        blue_cmp_hold  <= ltfc_pkg::FULL - blue_res.level;
        fan_cmp_hold   <= fan_level_next;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_deg_q   <= red_deg[7:0];
      white_deg_q <= white_deg[7:0];
      blue_deg_q  <= blue_deg[7:0];
    end
  end

  assign m_tdata = {(ltfc_pkg::OUT_W - ltfc_pkg::OUT_BITS)'(0),
                    blue_deg_q, white_deg_q, red_deg_q, fan_cmp_hold,
                    blue_cmp_hold, white_cmp_hold, red_cmp_hold,
                    driver_on, fault_q};

endmodule

// ===== hdl/ltfc_checker.sv =====
`include "assert_macros.svh"

module ltfc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [ltfc_pkg::OUT_W-1:0] m_tdata
);

  // A fault beat always switches the driver off and runs the fan full
  `ASSERT_CLKD(a_driver_vs_fault, clk, rst, m_tvalid |-> (m_tdata[1] == !m_tdata[0]), "driver_enable must be the inverse of over_temp_fault")
  `ASSERT_CLKD(a_fault_fan_full, clk, rst, (m_tvalid && m_tdata[0]) |-> (m_tdata[33:26] == 8'hFF), "fan compare must be 255 on a fault")

  // Level caps keep the LED compares above a floor, held values included
  `ASSERT_CLKD(a_cmp_floor, clk, rst, m_tvalid |-> ((m_tdata[9:2] >= 8'd17) && (m_tdata[17:10] >= 8'd13) && (m_tdata[25:18] >= 8'd13)), "LED compare below level cap floor")

  // A stalled result holds
  `ASSERT_CLKD(a_stall_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

  // Nothing is offered right after reset
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind led_thermal_fan_controller ltfc_checker u_ltfc_checker (.*);
